### rtl/ntf_pkg.sv
// Shared types, widths and codes of the note transposer.
// Used by the remainder unit and by the top level; no dependencies.
package ntf_pkg;

  // Fixed note geometry and default channel count.
  localparam int unsigned KEYS         = 128;
  localparam int unsigned CHANNELS_DEF = 16;

  // Field widths.
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CH_W     = 4;
  localparam int unsigned KEY_W    = 7;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned OUTKEY_W = 9;
  localparam int unsigned OFS_W    = 7;

  // Sequence arithmetic widths.
  localparam int unsigned START_W  = 5;
  localparam int unsigned BIAS_W   = 6;
  localparam int unsigned TERM_W   = 7;
  localparam int unsigned SUM_W    = 9;
  localparam int unsigned MOD_W    = 6;

  // Remainder unit: bits of the sum magnitude handled per cycle and cycle count.
  localparam int unsigned REM_STEPS  = 3;
  localparam int unsigned REM_CYCLES = 3;
  localparam int unsigned MAG_W      = REM_STEPS * REM_CYCLES;

  // Saturation bounds of the effective modulus.
  localparam int unsigned MOD_MIN = 1;
  localparam int unsigned MOD_MAX = 48;

  // Reset values of the start registers.
  localparam logic [START_W-1:0] START_CUR_RST  = 5'd0;
  localparam logic [START_W-1:0] START_PREV_RST = 5'd1;
  localparam logic [START_W-1:0] START_MOD_RST  = 5'd12;

  // Bus widths.
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 16;

  // Event modes carried in the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_NOTE_ON   = 3'd0,
    MODE_NOTE_OFF  = 3'd1,
    MODE_CHOKE     = 3'd2,
    MODE_EXPR      = 3'd3,
    MODE_TRANSPORT = 3'd4
  } mode_e;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_START_CUR  = 3'd0,
    REG_START_PREV = 3'd1,
    REG_START_MOD  = 3'd2,
    REG_BIAS_CUR   = 3'd3,
    REG_BIAS_PREV  = 3'd4,
    REG_BIAS_MOD   = 3'd5
  } reg_e;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic signed [OUTKEY_W-1:0] out_key;
    logic signed [OFS_W-1:0]    offset;
  } res_t;

  // Status of the remainder unit.
  typedef struct packed {
    logic                     done;
    logic signed [TERM_W-1:0] rem;
  } rem_stat_t;

endpackage

### rtl/ntf_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module ntf_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read-first registered read at the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ntf_rem.sv
// Multi-cycle truncating remainder of the sequence sum by the effective modulus.
// Depends on ntf_pkg.
module ntf_rem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ntf_pkg::SUM_W-1:0] sum_i,
  input  logic [ntf_pkg::MOD_W-1:0]        modulus_i,
  output ntf_pkg::rem_stat_t               stat_o
);
  import ntf_pkg::*;

  localparam int unsigned CNT_W = $clog2(REM_CYCLES);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [MAG_W-1:0] dvd_q;
  logic [MOD_W-1:0] rem_q;
  logic [MOD_W-1:0] rem_d;
  logic [MOD_W-1:0] mod_q;
  logic             neg_q;
  logic [MAG_W-1:0] mag;
  logic             last;
  logic [TERM_W-1:0] rem_mag;

  // Magnitude of the sum; the sign is applied to the remainder at the end.
  assign mag = sum_i[SUM_W-1] ? MAG_W'(-sum_i) : MAG_W'(sum_i);

  // Restoring steps over the next dividend bits, most significant first.
  always_comb begin
    logic [MOD_W:0] t;
    rem_d = rem_q;
    for (int j = 0; j < int'(REM_STEPS); j++) begin
      t = {rem_d, dvd_q[MAG_W-1-j]};
      if (t >= {1'b0, mod_q}) begin
        t = t - {1'b0, mod_q};
      end
      rem_d = t[MOD_W-1:0];
    end
  end

  assign last = busy_q && (cnt_q == CNT_W'(REM_CYCLES - 1));

  // Control: busy for a fixed number of cycles after a start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: shift the dividend and carry the partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag;
      rem_q <= '0;
      neg_q <= sum_i[SUM_W-1];
      mod_q <= modulus_i;
    end else if (busy_q) begin
      dvd_q <= dvd_q << REM_STEPS;
      rem_q <= rem_d;
    end
  end

  // The remainder takes the sign of the sum.
  assign rem_mag     = {1'b0, rem_d};
  assign stat_o.done = last;
  assign stat_o.rem  = neg_q ? $signed(-rem_mag) : $signed(rem_mag);

endmodule

### rtl/note_transposer_fibonacci_mod.sv
// Note event transposer: top level with the offset store, sequence state and bus ports.
// Depends on ntf_pkg, ntf_ram and ntf_rem.
//
// A note-on adds the current term of a Fibonacci-like sequence to its key, stores that
// offset for its channel and key, and steps the sequence modulo a biased, saturated
// modulus; note-off, choke and expression events add the stored offset. One item is in
// work at a time. A note-on occupies the transfer cycle and then the remainder unit,
// which resolves three bits of the sum per cycle. Note-off, choke and expression pass
// through a read state while the registered read of the offset RAM returns. Transport
// and unused modes complete in the transfer cycle. After reset the offset RAM is zeroed
// by a clearing pass over all CHANNELS*128 entries during which no item is taken;
// register writes are accepted throughout. A two-entry output buffer lets input
// transfers continue while a result waits on the output.
module note_transposer_fibonacci_mod #(
  parameter int unsigned CHANNELS = ntf_pkg::CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: channel [3:0], key [10:4], play flag [11], zero [15:12].
  input  logic [ntf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: mode [2:0].
  input  logic [ntf_pkg::MODE_W-1:0]      s_axis_tuser,
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: out_key [8:0], applied_offset [15:9].
  output logic [ntf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // tuser: event_kind [1:0].
  output logic [ntf_pkg::KIND_W-1:0]      m_axis_tuser,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ntf_pkg::APB_AW-1:0]      paddr,
  input  logic [ntf_pkg::APB_DW-1:0]      pwdata,
  output logic [ntf_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import ntf_pkg::*;

  localparam int unsigned DEPTH  = CHANNELS * KEYS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_STEP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [START_W-1:0] start_cur_q, start_cur_d;
  logic [START_W-1:0] start_prev_q, start_prev_d;
  logic [START_W-1:0] start_mod_q, start_mod_d;
  logic [BIAS_W-1:0]  bias_cur_q, bias_cur_d;
  logic [BIAS_W-1:0]  bias_prev_q, bias_prev_d;
  logic [BIAS_W-1:0]  bias_mod_q, bias_mod_d;
  logic               cfg_wr;
  logic               cfg_reload;
  reg_e               cfg_idx;

  // Sequence state.
  logic signed [TERM_W-1:0] cur_q;
  logic signed [TERM_W-1:0] prev_q;
  logic [START_W-1:0]       lmod_q;
  logic                     was_play_q;

  // Input item.
  logic              accept;
  mode_e             in_mode;
  logic [CH_W-1:0]   in_ch;
  logic [KEY_W-1:0]  in_key;
  logic              in_play;
  logic              in_ch_ok;
  logic              note_on;
  logic              transport;

  // Held item for the store read.
  logic [KIND_W-1:0] kind_q;
  logic [KEY_W-1:0]  key_q;
  logic              ch_ok_q;

  // Sequence step.
  logic signed [SUM_W-1:0] sum;
  logic signed [TERM_W-1:0] mod_raw;
  logic [MOD_W-1:0]        mod_eff;
  rem_stat_t               rem_stat;

  // Offset RAM and its clearing pass.
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              clr_last;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [OFS_W-1:0]  ram_wdata;
  logic [OFS_W-1:0]  ram_rdata;

  // Result buffering.
  logic              new_valid;
  res_t              new_res;
  logic signed [OFS_W-1:0] new_ofs;
  logic [KEY_W-1:0]  new_key;
  res_t              out_q, out_d, pend_q, pend_d;
  logic              out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  logic              out_free;

  // Input unpacking.
  assign in_mode   = mode_e'(s_axis_tuser);
  assign in_ch     = s_axis_tdata[CH_W-1:0];
  assign in_key    = s_axis_tdata[CH_W+KEY_W-1:CH_W];
  assign in_play   = s_axis_tdata[CH_W+KEY_W];
  assign in_ch_ok  = 32'(in_ch) < CHANNELS;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign note_on   = accept && (in_mode == MODE_NOTE_ON);
  assign transport = accept && (in_mode == MODE_TRANSPORT);

  assign s_axis_tready = (state_q == ST_IDLE) && !pend_valid_q;

  // Register write decode; pready is always high.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[4:2]);

  always_comb begin
    start_cur_d  = start_cur_q;
    start_prev_d = start_prev_q;
    start_mod_d  = start_mod_q;
    bias_cur_d   = bias_cur_q;
    bias_prev_d  = bias_prev_q;
    bias_mod_d   = bias_mod_q;
    cfg_reload   = 1'b0;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_START_CUR: begin
          start_cur_d = pwdata[START_W-1:0];
          cfg_reload  = 1'b1;
        end
        REG_START_PREV: begin
          start_prev_d = pwdata[START_W-1:0];
          cfg_reload   = 1'b1;
        end
        REG_START_MOD: begin
          start_mod_d = pwdata[START_W-1:0];
          cfg_reload  = 1'b1;
        end
        REG_BIAS_CUR:  bias_cur_d  = pwdata[BIAS_W-1:0];
        REG_BIAS_PREV: bias_prev_d = pwdata[BIAS_W-1:0];
        REG_BIAS_MOD:  bias_mod_d  = pwdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cur_q  <= START_CUR_RST;
      start_prev_q <= START_PREV_RST;
      start_mod_q  <= START_MOD_RST;
      bias_cur_q   <= '0;
      bias_prev_q  <= '0;
      bias_mod_q   <= '0;
    end else begin
      start_cur_q  <= start_cur_d;
      start_prev_q <= start_prev_d;
      start_mod_q  <= start_mod_d;
      bias_cur_q   <= bias_cur_d;
      bias_prev_q  <= bias_prev_d;
      bias_mod_q   <= bias_mod_d;
    end
  end

  // Register read-back, zero-extended.
  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_START_CUR:  prdata = APB_DW'(start_cur_q);
      REG_START_PREV: prdata = APB_DW'(start_prev_q);
      REG_START_MOD:  prdata = APB_DW'(start_mod_q);
      REG_BIAS_CUR:   prdata = APB_DW'(bias_cur_q);
      REG_BIAS_PREV:  prdata = APB_DW'(bias_prev_q);
      REG_BIAS_MOD:   prdata = APB_DW'(bias_mod_q);
      default:        prdata = '0;
    endcase
  end

  // Sum of the biased terms and the saturated modulus.
  assign sum = {{(SUM_W-TERM_W){cur_q[TERM_W-1]}}, cur_q}
             + {{(SUM_W-BIAS_W){bias_cur_q[BIAS_W-1]}}, bias_cur_q}
             + {{(SUM_W-TERM_W){prev_q[TERM_W-1]}}, prev_q}
             + {{(SUM_W-BIAS_W){bias_prev_q[BIAS_W-1]}}, bias_prev_q};

  assign mod_raw = $signed({2'b00, lmod_q}) + $signed({bias_mod_q[BIAS_W-1], bias_mod_q});

  always_comb begin
    if (mod_raw < $signed(TERM_W'(MOD_MIN))) begin
      mod_eff = MOD_W'(MOD_MIN);
    end else if (mod_raw > $signed(TERM_W'(MOD_MAX))) begin
      mod_eff = MOD_W'(MOD_MAX);
    end else begin
      mod_eff = mod_raw[MOD_W-1:0];
    end
  end

  ntf_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (note_on),
    .sum_i     (sum),
    .modulus_i (mod_eff),
    .stat_o    (rem_stat)
  );

  // Sequence state: reloads, the previous term shift and the new current term.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= TERM_W'($signed(START_CUR_RST));
      prev_q     <= TERM_W'($signed(START_PREV_RST));
      lmod_q     <= START_MOD_RST;
      was_play_q <= 1'b0;
    end else begin
      if (cfg_reload) begin
        cur_q  <= {{(TERM_W-START_W){start_cur_d[START_W-1]}}, start_cur_d};
        prev_q <= {{(TERM_W-START_W){start_prev_d[START_W-1]}}, start_prev_d};
        lmod_q <= start_mod_d;
      end else if (transport && in_play && !was_play_q) begin
        cur_q  <= {{(TERM_W-START_W){start_cur_q[START_W-1]}}, start_cur_q};
        prev_q <= {{(TERM_W-START_W){start_prev_q[START_W-1]}}, start_prev_q};
        lmod_q <= start_mod_q;
      end else if (note_on) begin
        prev_q <= cur_q;
      end else if (rem_stat.done) begin
        cur_q <= rem_stat.rem;
      end
      if (transport) begin
        was_play_q <= in_play;
      end
    end
  end

  // Control sequencer.
  assign clr_last = (clr_cnt_q == ADDR_W'(DEPTH - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_NOTE_ON:                        state_d = ST_STEP;
            MODE_NOTE_OFF, MODE_CHOKE, MODE_EXPR: state_d = ST_READ;
            default:                             state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_STEP: begin
        if (rem_stat.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
    end
  end

  // Item fields held for the cycle in which the store data returns.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_mode[KIND_W-1:0];
      key_q   <= in_key;
      ch_ok_q <= in_ch_ok;
    end
  end

  // Offset RAM port: clearing pass, note-on write, or lookup read.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = note_on && in_ch_ok;
      ram_addr  = ADDR_W'({in_ch, in_key});
      ram_wdata = cur_q;
    end
  end

  ntf_ram #(
    .WIDTH (OFS_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // New result: at a note-on transfer, or when the store data returns.
  assign new_valid = note_on || (state_q == ST_READ);

  always_comb begin
    if (state_q == ST_READ) begin
      new_res.kind = kind_q;
      new_ofs      = ch_ok_q ? $signed(ram_rdata) : '0;
      new_key      = key_q;
    end else begin
      new_res.kind = in_mode[KIND_W-1:0];
      new_ofs      = cur_q;
      new_key      = in_key;
    end
    new_res.offset  = new_ofs;
    new_res.out_key = $signed({2'b00, new_key})
                    + $signed({{(OUTKEY_W-OFS_W){new_ofs[OFS_W-1]}}, new_ofs});
  end

  // Output register with one pending entry behind it.
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (out_free) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
        if (new_valid) begin
          pend_d       = new_res;
          pend_valid_d = 1'b1;
        end
      end else if (new_valid) begin
        out_d       = new_res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (new_valid) begin
      pend_d       = new_res;
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.offset, out_q.out_key};
  assign m_axis_tuser  = out_q.kind;

endmodule
